// ===== sv/svr_pkg.sv =====
// ============================================================================
// svr_pkg
// Shared types, codes and fixed-point constants of the sawtooth voice.
// ============================================================================
package svr_pkg;

    // Default build parameters
    localparam int DEF_SAMPLE_RATE = 48000;
    localparam int DEF_PHASE_BITS  = 32;

    // Number of MIDI notes covered by the step table
    localparam int NOTE_COUNT = 128;

    // Input opcodes
    localparam logic [1:0] OPC_TICK     = 2'd0;
    localparam logic [1:0] OPC_NOTE_ON  = 2'd1;
    localparam logic [1:0] OPC_NOTE_OFF = 2'd2;

    // Fixed-point constants
    localparam logic [16:0] UNITY_Q15   = 17'd32768;    // 1.0 in Q1.15
    localparam logic [15:0] TAIL_START  = 16'd32768;    // release starts at 1.0
    localparam logic [15:0] DECAY_Q15   = 16'd32440;    // 0.99
    localparam logic [15:0] FLOOR_Q15   = 16'd1638;     // 0.05
    localparam logic [15:0] ROUND_Q15   = 16'd16384;    // half of one Q.15 step
    localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;

    // One octave of semitone ratios, Q1.24
    localparam bit [24:0] SEMITONE_Q24 [12] = '{
        25'd16777216, 25'd17774841, 25'd18831788, 25'd19951585,
        25'd21137968, 25'd22394897, 25'd23726566, 25'd25137421,
        25'd26632170, 25'd28215802, 25'd29893600, 25'd31671166
    };

    // Payload of one input item
    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] note_number;
        logic       allow_tail_off;
    } t_in_item;

    // Payload of one result item
    typedef struct packed {
        logic signed [16:0] sample_out;
        logic               voice_active;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAIL,
        ST_RAMP,
        ST_LEVEL,
        ST_GAIN,
        ST_DONE
    } t_state;

    // Operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_TAIL,
        MUL_RAMP,
        MUL_LEVEL,
        MUL_GAIN
    } t_mul_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic     note_on;
        logic     note_off_release;
        logic     note_off_stop;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     finish;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic sounding;
        logic releasing;
        logic out_free;
    } t_status;

endpackage

// ===== sv/svr_ctrl.sv =====
// ============================================================================
// svr_ctrl
// Sequencer: takes items, steps the shared multiplier through one sample
// and commits the result when the output register can take it.
// ============================================================================
module svr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_opcode,
    input  logic            i_allow_tail_off,
    input  svr_pkg::t_status i_status,
    output logic            o_in_ready,
    output svr_pkg::t_cmd   o_cmd
);
    import svr_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_TAIL;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_opcode)
                        OPC_TICK: begin
                            // silent voice goes straight to the result
                            if (!i_status.sounding) begin
                                n_state = ST_DONE;
                            end else if (i_status.releasing) begin
                                n_state = ST_TAIL;
                            end else begin
                                n_state = ST_RAMP;
                            end
                        end
                        OPC_NOTE_ON: begin
                            o_cmd.note_on = 1'b1;
                        end
                        OPC_NOTE_OFF: begin
                            o_cmd.note_off_release = i_allow_tail_off;
                            o_cmd.note_off_stop    = !i_allow_tail_off;
                        end
                        default: begin
                            // unused opcode: drop the item
                        end
                    endcase
                end
            end
            ST_TAIL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_TAIL;
                n_state       = ST_RAMP;
            end
            ST_RAMP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_RAMP;
                n_state       = ST_LEVEL;
            end
            ST_LEVEL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LEVEL;
                n_state       = ST_GAIN;
            end
            ST_GAIN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GAIN;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/svr_datapath.sv =====
// ============================================================================
// svr_datapath
// Voice state, note step table, shared multiplier and output register.
// ============================================================================
module svr_datapath #(
    parameter int SAMPLE_RATE = svr_pkg::DEF_SAMPLE_RATE,
    parameter int PHASE_BITS  = svr_pkg::DEF_PHASE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  svr_pkg::t_in_item  i_in_item,
    input  svr_pkg::t_cmd      i_cmd,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_out_ready,
    output svr_pkg::t_status   o_status,
    output logic               o_out_valid,
    output svr_pkg::t_out_item o_out_item
);
    import svr_pkg::*;

    // Voice state
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_step;
    logic [15:0]           r_tail;
    logic                  r_releasing;
    logic                  r_sounding;
    logic [15:0]           r_level;

    // Working registers
    logic signed [65:0]    r_prod;
    logic [15:0]           r_tail_next;

    // Output register
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [PHASE_BITS-1:0] w_step_rom [NOTE_COUNT];
    logic [31:0]           w_phase32;
    logic signed [30:0]    w_wrap;
    logic [16:0]           w_level;
    logic [16:0]           w_gain;
    logic signed [32:0]    w_mul_a;
    logic signed [32:0]    w_mul_b;
    logic signed [65:0]    w_prod;
    logic [30:0]           w_tail_sum;
    logic                  w_tail_end;

    // Phase step table, built at elaboration from the semitone ratios
    for (genvar gi = 0; gi < NOTE_COUNT; gi++) begin : g_step
        localparam int unsigned Key  = gi + 3;
        localparam int unsigned Oct  = Key / 12;
        localparam bit [63:0]   Num  = 64'(440) * 64'(SEMITONE_Q24[Key % 12]);
        localparam bit [63:0]   Quot = (Num << 29) / SAMPLE_RATE;
        localparam int unsigned Sh   = 59 - Oct - PHASE_BITS;
        localparam bit [63:0]   Rnd  = (Quot + (64'd1 << (Sh - 1))) >> Sh;
        assign w_step_rom[gi] = Rnd[PHASE_BITS-1:0];
    end

    // Wrap phase to a half cycle: the low 31 bits of the 32-bit phase, signed
    assign w_phase32 = 32'(r_phase) << (32 - PHASE_BITS);
    assign w_wrap    = $signed(w_phase32[30:0]);

    // Level clamped to unity, gain is the tail only while releasing
    assign w_level = (r_level > UNITY_Q15) ? UNITY_Q15 : {1'b0, r_level};
    assign w_gain  = r_releasing ? {1'b0, r_tail} : UNITY_Q15;

    // Shared multiplier operand selection
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_TAIL: begin
                w_mul_a = {17'd0, r_tail};
                w_mul_b = {17'd0, DECAY_Q15};
            end
            MUL_RAMP: begin
                w_mul_a = {{2{w_wrap[30]}}, w_wrap};
                w_mul_b = {1'b0, TWO_PI_Q29};
            end
            MUL_LEVEL: begin
                // ramp = floor(wrap * 2pi / 2^46)
                w_mul_a = {{16{r_prod[62]}}, r_prod[62:46]};
                w_mul_b = {16'd0, w_level};
            end
            MUL_GAIN: begin
                w_mul_a = {r_prod[31], r_prod[31:0]};
                w_mul_b = {16'd0, w_gain};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Decayed tail, rounded back to Q.15
    assign w_tail_sum = r_prod[30:0] + 31'(ROUND_Q15);
    assign w_tail_end = (r_tail_next <= FLOOR_Q15);

    // Product and decayed tail registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_en && (i_cmd.mul_sel == MUL_RAMP)) begin
            r_tail_next <= w_tail_sum[30:15];
        end
    end

    // Level register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cfg_we) begin
            r_level <= i_cfg_data;
        end
    end

    // Voice state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_tail      <= '0;
            r_releasing <= 1'b0;
            r_sounding  <= 1'b0;
        end else if (i_cmd.note_on) begin
            r_phase     <= '0;
            r_step      <= w_step_rom[i_in_item.note_number];
            r_tail      <= '0;
            r_releasing <= 1'b0;
            r_sounding  <= 1'b1;
        end else if (i_cmd.note_off_release) begin
            if (r_sounding && !r_releasing) begin
                r_releasing <= 1'b1;
                r_tail      <= TAIL_START;
            end
        end else if (i_cmd.note_off_stop) begin
            r_phase     <= '0;
            r_tail      <= '0;
            r_releasing <= 1'b0;
            r_sounding  <= 1'b0;
        end else if (i_cmd.finish && r_sounding) begin
            r_phase <= r_phase + r_step;
            if (r_releasing) begin
                if (w_tail_end) begin
                    r_sounding  <= 1'b0;
                    r_releasing <= 1'b0;
                    r_tail      <= '0;
                    r_step      <= '0;
                end else begin
                    r_tail <= r_tail_next;
                end
            end
        end
    end

    // Output register: load on finish, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_sounding) begin
                r_out_item.sample_out   <= r_prod[46:30];
                r_out_item.voice_active <= 1'b1;
            end else begin
                r_out_item.sample_out   <= '0;
                r_out_item.voice_active <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign o_status.sounding  = r_sounding;
    assign o_status.releasing = r_releasing;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

// ===== sv/sawtooth_voice_with_release.sv =====
// ============================================================================
// sawtooth_voice_with_release
// One sawtooth synthesizer voice with an exponential release tail.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_item): one item per tick,
//   note on or note off. Note on and note off take effect in the cycle they
//   are accepted and give no result. A tick gives exactly one result item
//   on the output channel (o_out_valid / i_out_ready, o_out_item).
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) writes
//   the Q1.15 output level; it is always ready. The user must write it
//   only while idle; the block does not enforce this. A tick on a sounding
//   voice runs three multiplies (four while releasing) through the one
//   shared 33x33 multiplier in states RAMP, LEVEL, GAIN (TAIL first while
//   releasing), then DONE registers its result; a tick on a silent voice
//   goes straight to DONE. The next item is accepted the cycle after the
//   result is registered; note commands are taken at one per cycle in IDLE.
//   A stalled receiver holds the result in the output register; the voice
//   still takes note commands, and a further tick waits for the register.
//   Reset (i_rst_n low, synchronous) silences the voice, clears phase, step,
//   tail and level, and empties the output register.
// ============================================================================
module sawtooth_voice_with_release #(
    parameter int SAMPLE_RATE = svr_pkg::DEF_SAMPLE_RATE,
    parameter int PHASE_BITS  = svr_pkg::DEF_PHASE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  svr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output svr_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);
    import svr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Level writes never stall
    assign o_cfg_ready = 1'b1;

    // Sequencer
    svr_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_opcode         (i_in_item.opcode),
        .i_allow_tail_off (i_in_item.allow_tail_off),
        .i_status         (w_status),
        .o_in_ready       (o_in_ready),
        .o_cmd            (w_cmd)
    );

    // Voice datapath
    svr_datapath #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/sv/tb_sawtooth_voice_with_release.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_sawtooth_voice_with_release
// Self-checking bench for the sawtooth voice. A queue-fed driver offers
// note on, note off, tick and unused-opcode items. A bit-exact voice
// predictor runs on every accepted item and queues the expected samples.
// A monitor compares each result with the oldest expected sample. The run
// steps through several output levels and sender/receiver idle patterns,
// and includes one long receiver stall.
// ============================================================================
module tb_sawtooth_voice_with_release;
    import svr_pkg::*;

    localparam int          PHASE_BITS  = DEF_PHASE_BITS;
    localparam logic [1:0]  OPC_UNUSED  = 2'd3;
    localparam int          SETTLE      = 12;
    localparam int          QUIET_LIMIT = 5000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_ITEMS = 45;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    // Stimulus and expected samples
    t_in_item  pending_items[$];
    t_out_item expected_samples[$];
    int        error_count;
    int        quiet_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      hold_req;
    logic      hold_req_q;
    int        hold_count;

    // Predicted voice state
    logic [31:0] v_phase;
    logic [31:0] v_step;
    logic [15:0] v_tail;
    logic        v_releasing;
    logic        v_sounding;
    logic [15:0] v_level;

    sawtooth_voice_with_release dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Phase increment of a MIDI note: semitone ratio, octave shift, round half up
    function automatic logic [31:0] note_phase_step(input logic [6:0] note);
        longint unsigned k;
        longint unsigned oct;
        longint unsigned num;
        longint unsigned quo;
        longint unsigned sh;
        k   = longint'(note) + 3;
        oct = k / 12;
        num = 64'd440 * longint'(SEMITONE_Q24[k % 12]);
        quo = (num << 29) / longint'(DEF_SAMPLE_RATE);
        sh  = 59 - oct - PHASE_BITS;
        return 32'((quo + (64'd1 << (sh - 1))) >> sh);
    endfunction

    // Sawtooth ramp in Q.15 from the current phase
    function automatic longint ramp_sample();
        logic [31:0] u;
        longint      w;
        u = (v_phase + 32'h4000_0000) & 32'h7FFF_FFFF;
        w = longint'(u) - 64'sh4000_0000;
        return (w * longint'(TWO_PI_Q29)) >>> 46;
    endfunction

    // Advance the voice by one accepted item, queue the sample a tick makes
    task automatic predict_voice(input t_in_item it);
        t_out_item   res;
        longint      lvl;
        longint      gain;
        longint      s;
        int unsigned nxt;
        case (it.opcode)
            OPC_NOTE_ON: begin
                v_phase     = '0;
                v_step      = note_phase_step(it.note_number);
                v_tail      = '0;
                v_releasing = 1'b0;
                v_sounding  = 1'b1;
            end
            OPC_NOTE_OFF: begin
                if (it.allow_tail_off) begin
                    if (v_sounding && !v_releasing) begin
                        v_releasing = 1'b1;
                        v_tail      = TAIL_START;
                    end
                end else begin
                    v_sounding  = 1'b0;
                    v_releasing = 1'b0;
                    v_tail      = '0;
                    v_phase     = '0;
                end
            end
            OPC_TICK: begin
                if (!v_sounding) begin
                    res.sample_out   = '0;
                    res.voice_active = 1'b0;
                end else begin
                    lvl  = (v_level > 16'd32768) ? longint'(UNITY_Q15) : longint'(v_level);
                    gain = v_releasing ? longint'(v_tail) : longint'(UNITY_Q15);
                    s    = (ramp_sample() * lvl * gain) >>> 30;
                    res.sample_out   = 17'(s);
                    res.voice_active = 1'b1;
                    v_phase = v_phase + v_step;
                    if (v_releasing) begin
                        nxt = (int'(v_tail) * int'(DECAY_Q15) + int'(ROUND_Q15)) >> 15;
                        if (nxt <= int'(FLOOR_Q15)) begin
                            v_sounding  = 1'b0;
                            v_releasing = 1'b0;
                            v_tail      = '0;
                            v_step      = '0;
                        end else begin
                            v_tail = 16'(nxt);
                        end
                    end
                end
                expected_samples.push_back(res);
            end
            default: begin
                // unused opcode: no effect, no result
            end
        endcase
    endtask

    function automatic t_in_item make_item(input logic [1:0] op, input logic [6:0] note,
                                           input logic tail_ok);
        t_in_item it;
        it.opcode         = op;
        it.note_number    = note;
        it.allow_tail_off = tail_ok;
        return it;
    endfunction

    task automatic push_ticks(input int n);
        repeat (n) pending_items.push_back(make_item(OPC_TICK, 7'($urandom), 1'($urandom)));
    endtask

    // Queue one phrase: mostly note on, ticks and an ending; sometimes noise
    task automatic push_phrase(inout int count);
        int n;
        if ($urandom_range(99) < 80) begin
            pending_items.push_back(make_item(OPC_NOTE_ON, 7'($urandom), 1'($urandom)));
            n = $urandom_range(24, 1);
            push_ticks(n);
            count += n + 1;
            case ($urandom_range(3))
                0, 1: begin
                    pending_items.push_back(make_item(OPC_NOTE_OFF, 7'($urandom), 1'b1));
                    n = ($urandom_range(99) < 40) ? $urandom_range(340, 290)
                                                  : $urandom_range(40, 0);
                    push_ticks(n);
                    count += n + 1;
                end
                2: begin
                    pending_items.push_back(make_item(OPC_NOTE_OFF, 7'($urandom), 1'b0));
                    n = $urandom_range(3, 0);
                    push_ticks(n);
                    count += n + 1;
                end
                default: begin
                end
            endcase
        end else begin
            n = $urandom_range(6, 1);
            repeat (n) begin
                pending_items.push_back(make_item(2'($urandom), 7'($urandom), 1'($urandom)));
            end
            count += n;
        end
    endtask

    // Wait until every item is taken and every sample has come back
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_level(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        v_level = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Input driver: predict on acceptance, then offer the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                predict_voice(i_in_item);
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_items.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_req_q  <= 1'b0;
            hold_count  <= 0;
        end else begin
            hold_req_q <= hold_req;
            if (hold_req && !hold_req_q) begin
                hold_count  <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_count > 0) begin
                hold_count  <= hold_count - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result monitor: compare against the oldest expected sample
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result: sample %0d active %0b",
                             o_out_item.sample_out, o_out_item.voice_active);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_out_item.sample_out !== want.sample_out
                        || o_out_item.voice_active !== want.voice_active) begin
                    if (error_count < 10)
                        $display("mismatch: expected sample %0d active %0b, got %0d %0b",
                                 want.sample_out, want.voice_active,
                                 o_out_item.sample_out, o_out_item.voice_active);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run after too long with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_sawtooth_voice_with_release failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sequence: reset, directed items, then random phases over levels and idling
    initial begin
        logic [15:0] levels[6];
        int          count;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        hold_req      = 1'b0;
        error_count   = 0;
        quiet_cycles  = 0;
        send_idle_pct = 7;
        recv_idle_pct = 56;
        v_phase       = '0;
        v_step        = '0;
        v_tail        = '0;
        v_releasing   = 1'b0;
        v_sounding    = 1'b0;
        v_level       = '0;
        levels = '{16'd32768, 16'hFFFF, 16'd0, 16'($urandom), 16'd1,
                   16'($urandom_range(32768))};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 56;
                recv_idle_pct = 7;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_level(levels[ph]);
            if (ph == 0) begin
                // tick and release on a silent voice, unused opcode
                push_ticks(1);
                pending_items.push_back(make_item(OPC_NOTE_OFF, 7'd0, 1'b1));
                pending_items.push_back(make_item(OPC_UNUSED, 7'd127, 1'b1));
                // lowest, middle and highest notes
                pending_items.push_back(make_item(OPC_NOTE_ON, 7'd69, 1'b0));
                push_ticks(3);
                pending_items.push_back(make_item(OPC_NOTE_ON, 7'd0, 1'b1));
                push_ticks(2);
                pending_items.push_back(make_item(OPC_NOTE_ON, 7'd127, 1'b0));
                push_ticks(2);
                // start a release, then a second release request is dropped
                pending_items.push_back(make_item(OPC_NOTE_OFF, 7'd127, 1'b1));
                push_ticks(2);
                pending_items.push_back(make_item(OPC_NOTE_OFF, 7'd5, 1'b1));
                push_ticks(1);
                // note on cancels the release, hard stop clears the phase
                pending_items.push_back(make_item(OPC_NOTE_ON, 7'd60, 1'b1));
                push_ticks(1);
                pending_items.push_back(make_item(OPC_NOTE_OFF, 7'd85, 1'b0));
                push_ticks(1);
                pending_items.push_back(make_item(OPC_NOTE_OFF, 7'd42, 1'b0));
                pending_items.push_back(make_item(OPC_UNUSED, 7'd0, 1'b0));
            end
            if (ph == 5) begin
                // long receiver stall while ticks keep coming
                hold_req = 1'b1;
                pending_items.push_back(make_item(OPC_NOTE_ON, 7'($urandom), 1'b0));
                push_ticks(60);
            end
            count = 0;
            while (count < PHASE_ITEMS)
                push_phrase(count);
            wait_drained();
        end

        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("tb_sawtooth_voice_with_release passed");
        end else begin
            $display("tb_sawtooth_voice_with_release failed");
        end
        $finish;
    end

endmodule
